/* src/pesr_pkg.sv */
`timescale 1ns / 1ps
// Package for the polyline equal-spacing resampler: widths, codes and shared types.
// No dependencies; the other files of the block, save pesr_ram, refer to it by scoped names.
package pesr_pkg;

    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_BITS_DEF  = 14;

    // Internal coordinate width, sized for the widest coordinate allowed.
    localparam int CW      = 16;
    localparam int LEN_W   = 33;   // Q17.16 segment length
    localparam int RAD_W   = 64;   // square root radicand
    localparam int DIVD_W  = 49;   // dividend, up to len << 16
    localparam int REM_W   = 36;   // partial remainder of the shared unit
    localparam int RES_W   = 33;   // root or quotient
    localparam int S_W     = 40;   // position along the segment, Q.16
    localparam int RUN_W   = 35;   // distance left / travelled, signed
    localparam int ITER_CW = 6;

    localparam logic [ITER_CW-1:0] SQRT_STEPS = 6'd32;
    localparam logic [ITER_CW-1:0] DIV_STEPS  = 6'd33;

    localparam logic [15:0] SEP_MIN   = 16'd64;
    localparam logic [15:0] SEP_RESET = 16'd640;
    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [35:0] HALF_Q16  = 36'h000008000;

    // Configuration register indexes
    localparam logic CFG_FILL_CORNERS = 1'b0;
    localparam logic CFG_POINT_SEP    = 1'b1;

    typedef enum logic
    {
        OP_SQRT,
        OP_DIV
    } iter_op_t;

    typedef struct packed
    {
        logic     start;
        iter_op_t op;
    } iter_cmd_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } iter_stat_t;

    typedef enum logic [4:0]
    {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_STEP_GO,
        ST_STEP_WAIT,
        ST_POS_GO,
        ST_POS_WAIT,
        ST_PX,
        ST_PY,
        ST_OFFER,
        ST_CORNER0,
        ST_ENDPT,
        ST_CLOSE,
        ST_RD,
        ST_OUT
    } state_t;

endpackage

/* src/polyline_equal_spacing_resampler_top.sv */
`timescale 1ns / 1ps
// Top level of the polyline equal-spacing resampler: sequencer, state, config.
// Depends on pesr_pkg, pesr_iter, pesr_pixel and pesr_ram.
//
//  channel   | direction | handshake          | contents
//  ----------+-----------+--------------------+----------------------------------------
//  s_axis    | in        | s_tvalid/s_tready  | tdata {vertex_y, vertex_x}, tuser
//            |           |                    | curve_start, tlast curve_end
//  m_axis    | out       | m_tvalid/m_tready  | tdata {point_y, point_x}, tuser
//            |           |                    | truncated, tlast last_of_run
//  cfg       | in        | cfg_we             | index 0 fill_corners, 1 point_separation
//
//  A curve start (or a vertex with no open curve) only anchors the curve. A segment is
//  squared (x, then y), then the square root and the step division run in the shared
//  unit, then the start position division when distance carries in, then each
//  candidate point takes two pixel interpolations through one multiplier; a corner
//  end point and the vertex close follow, and each emitted point is a result memory
//  read, then the output transaction.
//  Points of a vertex are buffered in the result memory so that last_of_run and
//  truncated are known before the first one leaves; the input is not ready until
//  the last point is taken. Output stalls hold the point; no clearing pass at reset.
module polyline_equal_spacing_resampler_top #(
    parameter int MAX_POINTS_PER_VERTEX = pesr_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS            = pesr_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // tdata: vertex_x [COORD_BITS-1:0], vertex_y above it, zero pad
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    // tuser: curve_start
    input  logic                                  s_tuser,
    input  logic                                  s_tlast,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // tdata: point_x [COORD_BITS-1:0], point_y above it, zero pad
    output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
    // tuser: truncated
    output logic                                  m_tuser,
    output logic                                  m_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_we,
    input  logic                                  cfg_index,
    input  logic [15:0]                           cfg_wdata
);

    localparam int TD_W  = ((2*COORD_BITS+7)/8)*8;
    localparam int PT_W  = 2*COORD_BITS;
    localparam int CNT_W = $clog2(MAX_POINTS_PER_VERTEX + 1);
    localparam int AW    = $clog2(MAX_POINTS_PER_VERTEX);
    localparam int CW    = pesr_pkg::CW;

    pesr_pkg::state_t state_reg, state_next;

    logic                  fill_reg, fill_next;
    logic [15:0]           sep_reg, sep_next;
    logic [CW-1:0]         prior_x_reg, prior_x_next, prior_y_reg, prior_y_next;
    logic [CW-1:0]         acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic                  fresh_reg, fresh_next;
    logic [31:0]           carried_reg, carried_next;
    logic                  open_reg, open_next;
    logic [CW-1:0]         vx_reg, vx_next, vy_reg, vy_next;
    logic                  end_reg, end_next;
    logic [32:0]           d2_reg, d2_next;
    logic [pesr_pkg::LEN_W-1:0] len_reg, len_next;
    logic [pesr_pkg::RES_W-1:0] step_reg, step_next;
    logic [pesr_pkg::S_W-1:0]   s_reg, s_next;
    logic signed [pesr_pkg::RUN_W-1:0] run_reg, run_next, run_upd;
    logic                  first_reg, first_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  drop_reg, drop_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;
    logic [CW-1:0]         px_reg, px_next;

    // shared datapath hooks
    logic [15:0]           mul_op;
    logic [31:0]           sq;
    logic [15:0]           sep_eff;
    logic signed [pesr_pkg::RUN_W-1:0] sep_s, len_s;
    logic [16:0]           s_clamp;
    logic [CW-1:0]         pix_a, pix_b, pix_out, pix_m;
    pesr_pkg::iter_cmd_t   iter_cmd;
    pesr_pkg::iter_stat_t  iter_stat;
    logic [pesr_pkg::RAD_W-1:0]  radicand;
    logic [pesr_pkg::DIVD_W-1:0] dividend;
    logic [pesr_pkg::RES_W-1:0]  iter_res;

    // offer path
    logic                  ofr_en, ofr_force, ofr_take;
    logic [CW-1:0]         ofr_x, ofr_y;
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr;
    logic [PT_W-1:0]       ram_wdata, ram_rdata;
    logic                  is_last;

    pesr_iter u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (iter_cmd),
        .radicand (radicand),
        .dividend (dividend),
        .divisor  (len_reg),
        .stat     (iter_stat),
        .result   (iter_res)
    );

    pesr_pixel u_pixel (
        .clk (clk),
        .a   (pix_a),
        .b   (pix_b),
        .s   (s_clamp),
        .pix (pix_out)
    );

    pesr_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_POINTS_PER_VERTEX)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // Fixed datapath pieces
    always_comb
    begin
        sq       = mul_op * mul_op;
        sep_eff  = (sep_reg < pesr_pkg::SEP_MIN) ? pesr_pkg::SEP_MIN : sep_reg;
        sep_s    = $signed(pesr_pkg::RUN_W'({sep_eff, 10'b0}));
        len_s    = $signed(pesr_pkg::RUN_W'(len_reg));
        s_clamp  = (s_reg > pesr_pkg::S_W'(pesr_pkg::ONE_Q16)) ? pesr_pkg::ONE_Q16
                                                              : s_reg[16:0];
        pix_m    = CW'(pix_out[COORD_BITS-1:0]);
        // large squared lengths lose two bits so the radicand stays in 64
        radicand = d2_reg[32] ? pesr_pkg::RAD_W'({d2_reg, 30'b0})
                              : {d2_reg[31:0], 32'b0};
        is_last  = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == cnt_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        sep_next     = sep_reg;
        prior_x_next = prior_x_reg;
        prior_y_next = prior_y_reg;
        acc_x_next   = acc_x_reg;
        acc_y_next   = acc_y_reg;
        fresh_next   = fresh_reg;
        carried_next = carried_reg;
        open_next    = open_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        end_next     = end_reg;
        d2_next      = d2_reg;
        len_next     = len_reg;
        step_next    = step_reg;
        s_next       = s_reg;
        run_next     = run_reg;
        run_upd      = run_reg;
        first_next   = first_reg;
        cnt_next     = cnt_reg;
        drop_next    = drop_reg;
        rd_idx_next  = rd_idx_reg;
        px_next      = px_reg;

        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        mul_op       = (vx_reg >= prior_x_reg) ? (vx_reg - prior_x_reg) : (prior_x_reg - vx_reg);
        iter_cmd     = '{start: 1'b0, op: pesr_pkg::OP_DIV};
        dividend     = pesr_pkg::DIVD_W'({sep_eff, 26'b0});
        pix_a        = prior_x_reg;
        pix_b        = vx_reg;
        ram_re       = 1'b0;
        ofr_en       = 1'b0;
        ofr_force    = 1'b1;
        ofr_x        = vx_reg;
        ofr_y        = vy_reg;

        // configuration writes are to be made only while idle; the block itself does not enforce this
        if (cfg_we)
        begin
            case (cfg_index)
                pesr_pkg::CFG_FILL_CORNERS: fill_next = cfg_wdata[0];
                pesr_pkg::CFG_POINT_SEP:    sep_next  = cfg_wdata;
                default:                    sep_next  = sep_reg;
            endcase
        end

        case (state_reg)
            pesr_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    vx_next   = CW'(s_tdata[COORD_BITS-1:0]);
                    vy_next   = CW'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
                    end_next  = s_tlast;
                    cnt_next  = '0;
                    drop_next = 1'b0;
                    if (s_tuser || !open_reg)
                    begin
                        // new curve: anchor everything at this vertex
                        prior_x_next = CW'(s_tdata[COORD_BITS-1:0]);
                        prior_y_next = CW'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
                        acc_x_next   = CW'(s_tdata[COORD_BITS-1:0]);
                        acc_y_next   = CW'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
                        fresh_next   = 1'b1;
                        carried_next = '0;
                        open_next    = !s_tlast;
                    end
                    else
                    begin
                        state_next = pesr_pkg::ST_SQ_X;
                    end
                end
            end

            pesr_pkg::ST_SQ_X:
            begin
                d2_next    = 33'(sq);
                state_next = pesr_pkg::ST_SQ_Y;
            end

            pesr_pkg::ST_SQ_Y:
            begin
                mul_op     = (vy_reg >= prior_y_reg) ? (vy_reg - prior_y_reg)
                                                     : (prior_y_reg - vy_reg);
                d2_next    = d2_reg + 33'(sq);
                state_next = pesr_pkg::ST_ROOT_GO;
            end

            pesr_pkg::ST_ROOT_GO:
            begin
                iter_cmd   = '{start: 1'b1, op: pesr_pkg::OP_SQRT};
                state_next = pesr_pkg::ST_ROOT_WAIT;
            end

            pesr_pkg::ST_ROOT_WAIT:
            begin
                if (iter_stat.done)
                begin
                    len_next = d2_reg[32] ? {iter_res[31:0], 1'b0} : {1'b0, iter_res[31:0]};
                    if (fill_reg)
                    begin
                        carried_next = '0;
                        state_next   = (d2_reg == '0) ? pesr_pkg::ST_CORNER0
                                                      : pesr_pkg::ST_STEP_GO;
                    end
                    else
                    begin
                        // zero-length segment: skip it
                        state_next = (d2_reg == '0) ? pesr_pkg::ST_CLOSE
                                                    : pesr_pkg::ST_STEP_GO;
                    end
                end
            end

            pesr_pkg::ST_STEP_GO:
            begin
                iter_cmd   = '{start: 1'b1, op: pesr_pkg::OP_DIV};
                state_next = pesr_pkg::ST_STEP_WAIT;
            end

            pesr_pkg::ST_STEP_WAIT:
            begin
                if (iter_stat.done)
                begin
                    step_next = iter_res;
                    if (fill_reg)
                    begin
                        s_next     = '0;
                        run_next   = len_s;
                        first_next = 1'b1;
                        state_next = pesr_pkg::ST_PX;
                    end
                    else
                    begin
                        run_next = $signed(pesr_pkg::RUN_W'(carried_reg));
                        if (pesr_pkg::LEN_W'(carried_reg) <= len_reg)
                        begin
                            state_next = pesr_pkg::ST_POS_GO;
                        end
                        else
                        begin
                            // carry overshoots the whole segment
                            carried_next = carried_reg - 32'(len_reg);
                            state_next   = pesr_pkg::ST_CLOSE;
                        end
                    end
                end
            end

            pesr_pkg::ST_POS_GO:
            begin
                dividend   = {run_reg[pesr_pkg::LEN_W-1:0], 16'h0000};
                iter_cmd   = '{start: 1'b1, op: pesr_pkg::OP_DIV};
                state_next = pesr_pkg::ST_POS_WAIT;
            end

            pesr_pkg::ST_POS_WAIT:
            begin
                dividend = {run_reg[pesr_pkg::LEN_W-1:0], 16'h0000};
                if (iter_stat.done)
                begin
                    s_next     = pesr_pkg::S_W'(iter_res);
                    state_next = pesr_pkg::ST_PX;
                end
            end

            pesr_pkg::ST_PX:
            begin
                state_next = pesr_pkg::ST_PY;
            end

            pesr_pkg::ST_PY:
            begin
                pix_a      = prior_y_reg;
                pix_b      = vy_reg;
                px_next    = pix_m;
                state_next = pesr_pkg::ST_OFFER;
            end

            pesr_pkg::ST_OFFER:
            begin
                ofr_en = 1'b1;
                ofr_x  = px_reg;
                ofr_y  = pix_m;
                s_next = s_reg + pesr_pkg::S_W'(step_reg);
                if (fill_reg)
                begin
                    ofr_force  = first_reg;
                    first_next = 1'b0;
                    run_upd    = run_reg - sep_s;
                    run_next   = run_upd;
                    if (run_upd >= sep_s)
                    begin
                        state_next = pesr_pkg::ST_PX;
                    end
                    else
                    begin
                        fresh_next = 1'b0;
                        state_next = end_reg ? pesr_pkg::ST_ENDPT : pesr_pkg::ST_CLOSE;
                    end
                end
                else
                begin
                    ofr_force  = fresh_reg;
                    fresh_next = 1'b0;
                    run_upd    = run_reg + sep_s;
                    run_next   = run_upd;
                    if (run_upd <= len_s)
                    begin
                        state_next = pesr_pkg::ST_PX;
                    end
                    else
                    begin
                        carried_next = 32'(run_upd - len_s);
                        state_next   = pesr_pkg::ST_CLOSE;
                    end
                end
            end

            pesr_pkg::ST_CORNER0:
            begin
                // zero-length corner segment offers only its start
                ofr_en     = 1'b1;
                ofr_x      = prior_x_reg;
                ofr_y      = prior_y_reg;
                fresh_next = 1'b0;
                state_next = end_reg ? pesr_pkg::ST_ENDPT : pesr_pkg::ST_CLOSE;
            end

            pesr_pkg::ST_ENDPT:
            begin
                ofr_en     = 1'b1;
                state_next = pesr_pkg::ST_CLOSE;
            end

            pesr_pkg::ST_CLOSE:
            begin
                prior_x_next = vx_reg;
                prior_y_next = vy_reg;
                if (end_reg)
                begin
                    open_next = 1'b0;
                end
                rd_idx_next = '0;
                state_next  = (cnt_reg != '0) ? pesr_pkg::ST_RD : pesr_pkg::ST_IDLE;
            end

            pesr_pkg::ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = pesr_pkg::ST_OUT;
            end

            pesr_pkg::ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (is_last)
                    begin
                        state_next = pesr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                        state_next  = pesr_pkg::ST_RD;
                    end
                end
            end

            default:
            begin
                state_next = pesr_pkg::ST_IDLE;
            end
        endcase

        // Offer: keep a point that is forced or moves off the last pixel;
        // drop it once the per-vertex buffer is full.
        ofr_take  = ofr_en && (ofr_force || (ofr_x != acc_x_reg) || (ofr_y != acc_y_reg));
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[AW-1:0];
        ram_wdata = {ofr_y[COORD_BITS-1:0], ofr_x[COORD_BITS-1:0]};
        if (ofr_take)
        begin
            if (cnt_reg < CNT_W'(MAX_POINTS_PER_VERTEX))
            begin
                ram_we     = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                acc_x_next = ofr_x;
                acc_y_next = ofr_y;
            end
            else
            begin
                drop_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pesr_pkg::ST_IDLE;
            fill_reg    <= 1'b0;
            sep_reg     <= pesr_pkg::SEP_RESET;
            prior_x_reg <= '0;
            prior_y_reg <= '0;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            fresh_reg   <= 1'b1;
            carried_reg <= '0;
            open_reg    <= 1'b0;
            cnt_reg     <= '0;
            drop_reg    <= 1'b0;
            rd_idx_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            sep_reg     <= sep_next;
            prior_x_reg <= prior_x_next;
            prior_y_reg <= prior_y_next;
            acc_x_reg   <= acc_x_next;
            acc_y_reg   <= acc_y_next;
            fresh_reg   <= fresh_next;
            carried_reg <= carried_next;
            open_reg    <= open_next;
            cnt_reg     <= cnt_next;
            drop_reg    <= drop_next;
            rd_idx_reg  <= rd_idx_next;
        end
    end

    // working registers of the current vertex
    always_ff @(posedge clk)
    begin
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        end_reg   <= end_next;
        d2_reg    <= d2_next;
        len_reg   <= len_next;
        step_reg  <= step_next;
        s_reg     <= s_next;
        run_reg   <= run_next;
        first_reg <= first_next;
        px_reg    <= px_next;
    end

    assign m_tdata = TD_W'(ram_rdata);
    assign m_tlast = is_last;
    assign m_tuser = drop_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_POINTS_PER_VERTEX))
        else $error("point count beyond buffer depth");

    a_in_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while a point is presented");

    a_iter_owned: assert property (@(posedge clk) disable iff (!rst_n)
        iter_stat.busy |-> (state_reg == pesr_pkg::ST_ROOT_WAIT ||
                            state_reg == pesr_pkg::ST_STEP_WAIT ||
                            state_reg == pesr_pkg::ST_POS_WAIT))
        else $error("shared unit busy outside a wait state");

    a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (cnt_reg != '0))
        else $error("point presented from an empty buffer");

    a_run_return: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready after last point of a run");

endmodule

/* src/pesr_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pesr_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/pesr_iter.sv */
`timescale 1ns / 1ps
// Shared compare-and-subtract unit: floor square root (two bits a cycle) or
// restoring division (one bit a cycle). Depends on pesr_pkg.
module pesr_iter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pesr_pkg::iter_cmd_t             cmd,
    input  logic [pesr_pkg::RAD_W-1:0]      radicand,
    input  logic [pesr_pkg::DIVD_W-1:0]     dividend,
    input  logic [pesr_pkg::LEN_W-1:0]      divisor,
    output pesr_pkg::iter_stat_t            stat,
    output logic [pesr_pkg::RES_W-1:0]      result
);

    pesr_pkg::iter_op_t              op_reg;
    logic [pesr_pkg::REM_W-1:0]      rem_reg;
    logic [pesr_pkg::RAD_W-1:0]      src_reg;
    logic [pesr_pkg::RES_W-1:0]      res_reg;
    logic [pesr_pkg::LEN_W-1:0]      div_reg;
    logic [pesr_pkg::ITER_CW-1:0]    cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;

    logic [pesr_pkg::REM_W-1:0]      shifted;
    logic [pesr_pkg::REM_W-1:0]      trial;
    logic                            ge;

    always_comb
    begin
        if (op_reg == pesr_pkg::OP_SQRT)
        begin
            shifted = {rem_reg[pesr_pkg::REM_W-3:0], src_reg[pesr_pkg::RAD_W-1 -: 2]};
            trial   = {1'b0, res_reg, 2'b01};
        end
        else
        begin
            shifted = {rem_reg[pesr_pkg::REM_W-2:0], src_reg[pesr_pkg::RAD_W-1]};
            trial   = {3'b000, div_reg};
        end
        ge = (shifted >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= pesr_pkg::OP_SQRT;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= cmd.op;
                cnt_reg  <= (cmd.op == pesr_pkg::OP_SQRT) ? pesr_pkg::SQRT_STEPS
                                                          : pesr_pkg::DIV_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == pesr_pkg::ITER_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            res_reg <= '0;
            div_reg <= divisor;
            if (cmd.op == pesr_pkg::OP_SQRT)
            begin
                rem_reg <= '0;
                src_reg <= radicand;
            end
            else
            begin
                // top 16 dividend bits are below any non-zero length
                rem_reg <= pesr_pkg::REM_W'(dividend[pesr_pkg::DIVD_W-1:pesr_pkg::LEN_W]);
                src_reg <= {dividend[pesr_pkg::LEN_W-1:0],
                            (pesr_pkg::RAD_W - pesr_pkg::LEN_W)'(0)};
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (shifted - trial) : shifted;
            res_reg <= {res_reg[pesr_pkg::RES_W-2:0], ge};
            if (op_reg == pesr_pkg::OP_SQRT)
            begin
                src_reg <= {src_reg[pesr_pkg::RAD_W-3:0], 2'b00};
            end
            else
            begin
                src_reg <= {src_reg[pesr_pkg::RAD_W-2:0], 1'b0};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

endmodule

/* src/pesr_pixel.sv */
`timescale 1ns / 1ps
// Interpolates one coordinate at position s and rounds half up to a pixel.
// One multiplier, registered result. Depends on pesr_pkg.
module pesr_pixel (
    input  logic                     clk,
    input  logic [pesr_pkg::CW-1:0]  a,
    input  logic [pesr_pkg::CW-1:0]  b,
    input  logic [16:0]              s,
    output logic [pesr_pkg::CW-1:0]  pix
);

    logic signed [16:0] diff;
    logic signed [34:0] prod;
    logic signed [35:0] p;
    logic        [35:0] rounded;

    always_comb
    begin
        diff    = $signed({1'b0, b}) - $signed({1'b0, a});
        prod    = diff * $signed({1'b0, s});
        p       = $signed({4'b0000, a, 16'h0000}) + 36'(prod);
        rounded = (p < 0) ? 36'd0 : ($unsigned(p) + pesr_pkg::HALF_Q16);
    end

    always_ff @(posedge clk)
    begin
        pix <= rounded[31:16];
    end

endmodule

/* tb/polyline_equal_spacing_resampler_top_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for polyline_equal_spacing_resampler_top: streams vertices in, checks
// every resampled point against a fixed-point resampler model kept in the bench.
// Depends on pesr_pkg and the block's RTL.
module polyline_equal_spacing_resampler_top_test;

    localparam int CB       = 14;
    localparam int MAX_PTS  = 64;
    localparam int IDLE_PCT = 19;
    // cycles allowed for a vertex that may still be busy without producing a point
    localparam int SETTLE   = 8000;

    typedef struct packed
    {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          curve_start;
        logic          curve_end;
    } vertex_t;

    typedef struct packed
    {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          run_last;
        logic          truncated;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    polyline_equal_spacing_resampler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),   // vertex_x [13:0], vertex_y [27:14], zero pad
        .s_tuser   (s_tuser),   // curve_start
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),   // point_x [13:0], point_y [27:14], zero pad
        .m_tuser   (m_tuser),   // truncated
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    vertex_t vertex_queue[$];
    point_t  due_points[$];
    int      errors;
    bit      hold_sender;   // sender pause requested by the stimulus
    bit      quiet;         // stretch with no idling on either side

    // Shadow of the block's configuration and state
    bit              corner_mode;
    logic [15:0]     separation;
    logic [CB-1:0]   prev_x, prev_y, acc_x, acc_y;
    bit              fresh_curve;
    logic [31:0]     carry_dist;
    bit              curve_live;
    point_t          step_points[$];
    bit              step_dropped;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        errors++;
    endtask

    // floor square root of a 64-bit value, digit by digit
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // interpolate one coordinate at fraction s (Q1.16, clamped to 1.0), round half up
    function automatic logic [CB-1:0] lerp_pixel(input longint a, input longint b,
                                                 input longint s);
        longint p;
        if (s > 65536)
            s = 65536;
        p = a * 65536 + (b - a) * s;
        if (p < 0)
            p = 0;
        return CB'((p + 32768) >>> 16);
    endfunction

    task automatic offer_point(input logic [CB-1:0] px, input logic [CB-1:0] py,
                               input bit forced);
        point_t pt;
        if (forced || px != acc_x || py != acc_y)
        begin
            if (step_points.size() < MAX_PTS)
            begin
                pt = '{px, py, 1'b0, 1'b0};
                step_points.push_back(pt);
                acc_x = px;
                acc_y = py;
            end
            else
                step_dropped = 1'b1;
        end
    endtask

    // Work out the points that one accepted vertex produces and queue them
    task automatic resample_vertex(input vertex_t v);
        longint          sep, dx, dy, len, stride, pos, left, dc;
        longint unsigned d2;
        bit              lead;
        point_t          pt;
        step_points  = {};
        step_dropped = 1'b0;
        if (v.curve_start || !curve_live)
        begin
            prev_x      = v.x;
            prev_y      = v.y;
            acc_x       = v.x;
            acc_y       = v.y;
            fresh_curve = 1'b1;
            carry_dist  = '0;
            curve_live  = !v.curve_end;
            return;
        end
        sep = (separation < 16'd64) ? 64 : separation;
        sep = sep << 10;
        dx  = longint'(v.x) - longint'(prev_x);
        dy  = longint'(v.y) - longint'(prev_y);
        d2  = dx * dx + dy * dy;
        if (d2 < (64'd1 << 32))
            len = floor_root(d2 << 32);
        else
            len = floor_root(d2 << 30) << 1;
        if (corner_mode)
        begin
            carry_dist = '0;
            if (len == 0)
                offer_point(prev_x, prev_y, 1'b1);
            else
            begin
                stride = (sep << 16) / len;
                pos    = 0;
                left   = len;
                lead   = 1'b1;
                do
                begin
                    offer_point(lerp_pixel(prev_x, v.x, pos), lerp_pixel(prev_y, v.y, pos),
                                lead);
                    lead = 1'b0;
                    left -= sep;
                    pos  += stride;
                end
                while (left >= sep);
            end
            fresh_curve = 1'b0;
            if (v.curve_end)
                offer_point(v.x, v.y, 1'b1);
        end
        else if (len > 0)
        begin
            dc     = carry_dist;
            stride = (sep << 16) / len;
            pos    = (dc <= len) ? (dc << 16) / len : 65536;
            while (dc <= len)
            begin
                offer_point(lerp_pixel(prev_x, v.x, pos), lerp_pixel(prev_y, v.y, pos),
                            fresh_curve);
                fresh_curve = 1'b0;
                dc  += sep;
                pos += stride;
            end
            carry_dist = 32'(dc - len);
        end
        prev_x = v.x;
        prev_y = v.y;
        if (v.curve_end)
            curve_live = 1'b0;
        foreach (step_points[k])
        begin
            pt           = step_points[k];
            pt.run_last  = (k == step_points.size() - 1);
            pt.truncated = step_dropped;
            due_points.push_back(pt);
        end
    endtask

    // Driver: predict on each accepted transaction, then present the next vertex
    always @(posedge clk or negedge rst_n)
    begin
        vertex_t nv;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                resample_vertex('{s_tdata[CB-1:0], s_tdata[2*CB-1:CB], s_tuser, s_tlast});
            if (!s_tvalid || s_tready)
            begin
                if (vertex_queue.size() != 0 && !hold_sender &&
                    (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    nv = vertex_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, nv.y, nv.x};
                    s_tuser  <= nv.curve_start;
                    s_tlast  <= nv.curve_end;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure, compare each accepted point with the oldest one due
    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_points.size() == 0)
                    report($sformatf("unexpected point x=%0d y=%0d",
                                     m_tdata[CB-1:0], m_tdata[2*CB-1:CB]));
                else
                begin
                    want = due_points.pop_front();
                    if (m_tdata[CB-1:0] !== want.x)
                        report($sformatf("point_x %0d, want %0d", m_tdata[CB-1:0], want.x));
                    if (m_tdata[2*CB-1:CB] !== want.y)
                        report($sformatf("point_y %0d, want %0d",
                                         m_tdata[2*CB-1:CB], want.y));
                    if (m_tdata[31:2*CB] !== '0)
                        report("tdata padding not zero");
                    if (m_tlast !== want.run_last)
                        report($sformatf("last_of_run %b, want %b", m_tlast, want.run_last));
                    if (m_tuser !== want.truncated)
                        report($sformatf("truncated %b, want %b", m_tuser, want.truncated));
                end
            end
            m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic add_vertex(input int x, input int y, input bit cs, input bit ce);
        vertex_t v;
        v = '{CB'(x), CB'(y), cs, ce};
        vertex_queue.push_back(v);
    endtask

    // Wait until the block is idle: all vertices taken, all points out, nothing in flight
    task automatic settle();
        wait (vertex_queue.size() == 0);
        @(posedge clk iff !s_tvalid);
        wait (due_points.size() == 0);
        repeat (SETTLE) @(posedge clk);
        @(posedge clk iff s_tready);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == pesr_pkg::CFG_FILL_CORNERS)
            corner_mode = val[0];
        else
            separation = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One polyline with random content; long jumps only where the spacing keeps them cheap
    task automatic add_polyline(input bit long_ok);
        int x, y, n, step;
        x = $urandom_range(16383);
        y = $urandom_range(16383);
        n = $urandom_range(6, 1);
        add_vertex(x, y, 1'b1, 1'b0);
        for (int i = 0; i < n; i++)
        begin
            step = (long_ok && $urandom_range(9) == 0) ? 3000 : 40;
            if ($urandom_range(9) == 0)
                step = 0;
            x = x + $urandom_range(2 * step) - step;
            y = y + $urandom_range(2 * step) - step;
            x = (x < 0) ? 0 : (x > 16383) ? 16383 : x;
            y = (y < 0) ? 0 : (y > 16383) ? 16383 : y;
            // occasional noise: stray start or end flags
            if ($urandom_range(9) == 0)
                add_vertex(x, y, $urandom_range(1), $urandom_range(1));
            else
                add_vertex(x, y, 1'b0, i == n - 1);
        end
    endtask

    initial
    begin
        logic [15:0] sep_pick;
        int          sent;
        errors      = 0;
        hold_sender = 1'b0;
        quiet       = 1'b0;
        corner_mode = 1'b0;
        separation  = pesr_pkg::SEP_RESET;
        prev_x      = '0;
        prev_y      = '0;
        acc_x       = '0;
        acc_y       = '0;
        fresh_curve = 1'b1;
        carry_dist  = '0;
        curve_live  = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = 1'b0;
        cfg_wdata   = '0;
        rst_n       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset configuration: carried distance, truncation, zero-length segment
        add_vertex(0, 0, 1'b0, 1'b0);          // no open curve: acts as a start
        add_vertex(16383, 0, 1'b0, 1'b0);      // long segment, hits the per-vertex limit
        add_vertex(16383, 0, 1'b0, 1'b0);      // zero length, skipped
        add_vertex(16383, 16383, 1'b0, 1'b1);
        add_vertex(5, 7, 1'b1, 1'b1);          // start and end together: closes at once
        add_vertex(9, 9, 1'b0, 1'b0);
        add_vertex(30, 21, 1'b0, 1'b1);
        settle();

        // Corner mode at the finest spacing
        write_reg(pesr_pkg::CFG_FILL_CORNERS, 16'd1);
        write_reg(pesr_pkg::CFG_POINT_SEP, 16'd64);
        add_vertex(100, 100, 1'b1, 1'b0);
        add_vertex(110, 100, 1'b0, 1'b0);
        add_vertex(110, 100, 1'b0, 1'b0);      // zero length: start point only
        add_vertex(40, 140, 1'b0, 1'b0);       // 80 px: over the limit
        add_vertex(100, 140, 1'b0, 1'b1);
        settle();

        // Widest spacing in both modes
        write_reg(pesr_pkg::CFG_POINT_SEP, 16'hFFFF);
        add_vertex(0, 0, 1'b1, 1'b0);
        add_vertex(16383, 16383, 1'b0, 1'b1);
        settle();
        write_reg(pesr_pkg::CFG_FILL_CORNERS, 16'd0);
        add_vertex(16383, 16383, 1'b1, 1'b0);
        add_vertex(0, 0, 1'b0, 1'b0);
        add_vertex(3000, 0, 1'b0, 1'b1);
        settle();

        // Random phases over several settings
        for (int ph = 0; ph < 6; ph++)
        begin
            sep_pick = (ph % 3 == 0) ? 16'(64 + $urandom_range(200)) :
                       (ph % 3 == 1) ? 16'(640 + $urandom_range(3000)) :
                                       16'($urandom_range(65535, 64));
            write_reg(pesr_pkg::CFG_FILL_CORNERS, 16'(ph & 1));
            write_reg(pesr_pkg::CFG_POINT_SEP, sep_pick);
            quiet = (ph == 2);
            sent  = 0;
            while (sent < 30)
            begin
                add_polyline(sep_pick >= 16'd640);
                sent += 5;
            end
            if (ph == 3)
            begin
                // let the sender wait until every point is out, then carry on
                wait (vertex_queue.size() < 10);
                hold_sender = 1'b1;
                wait (due_points.size() == 0);
                repeat (50) @(posedge clk);
                hold_sender = 1'b0;
            end
            settle();
        end
        quiet = 1'b0;

        if (due_points.size() != 0)
            report($sformatf("%0d points never arrived", due_points.size()));
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
